>>> design/rcpe_pkg.sv
// Shared types and constants for the remote code pulse encoder.
`timescale 1ns / 1ps
package rcpe_pkg;

   localparam int RCPE_SYMBOLS = 12;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] CODE_MAX = 16'h0FFF;
   localparam logic [15:0] WIDTH_MAX = 16'd32767;

   localparam logic [14:0] BASE_PULSE_RESET = 15'd350;
   localparam logic [7:0] PILOT_MULT_RESET = 8'd36;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_BAD_REQ = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      REG_BASE_PULSE = 1'b0,
      REG_PILOT_MULT = 1'b1
   } reg_index_type;

   // One classified request on its way from the front end to the sequencer.
   typedef struct packed {
      status_type status;
      logic [15:0] code;
      logic [14:0] t;
      logic [14:0] pilot;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

>>> design/rcpe_front.sv
// Front end: configuration registers, request checks and width precompute.
`timescale 1ns / 1ps
module rcpe_front #(
   parameter int SYMBOLS = rcpe_pkg::RCPE_SYMBOLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            code,
   input  logic                   protocol_ok,
   input  logic [7:0]             symbol_count,
   input  logic [15:0]            capacity,
   input  rcpe_pkg::qstat_type    q_stat,
   output logic                   push,
   output rcpe_pkg::cmd_type      cmd
);
   import rcpe_pkg::*;

   localparam int TRAIN_LEN = 2 + 2 * SYMBOLS;

   logic [14:0] base_pulse_ff, base_pulse_in;
   logic [7:0]  pilot_mult_ff, pilot_mult_in;
   logic [22:0] pilot_full;
   logic        bad_req;
   logic        bad_width;

   assign csr_ready = 1'b1;

   always_comb begin
      base_pulse_in = base_pulse_ff;
      pilot_mult_in = pilot_mult_ff;
      if (csr_valid) begin
         unique case (reg_index_type'(csr_index))
            REG_BASE_PULSE: base_pulse_in = csr_wdata[14:0];
            REG_PILOT_MULT: pilot_mult_in = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_pulse_ff <= BASE_PULSE_RESET;
         pilot_mult_ff <= PILOT_MULT_RESET;
      end else begin
         base_pulse_ff <= base_pulse_in;
         pilot_mult_ff <= pilot_mult_in;
      end
   end

   assign pilot_full = 23'(base_pulse_ff) * 23'(pilot_mult_ff);

   assign bad_req = !protocol_ok || (symbol_count != 8'(SYMBOLS)) || (code > CODE_MAX) ||
                    (capacity < 16'(TRAIN_LEN));

   // Twice the base width overflows exactly when the top bit of the base is set.
   assign bad_width = (base_pulse_ff == 15'd0) || base_pulse_ff[14] ||
                      (pilot_full == 23'd0) || (pilot_full > 23'(WIDTH_MAX));

   always_comb begin
      cmd.code  = code;
      cmd.t     = base_pulse_ff;
      cmd.pilot = pilot_full[14:0];
      priority if (bad_req) begin
         cmd.status = STATUS_BAD_REQ;
      end else if (bad_width) begin
         cmd.status = STATUS_RANGE;
      end else begin
         cmd.status = STATUS_OK;
      end
   end

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && !q_stat.full;

endmodule

>>> design/rcpe_queue.sv
// Short command queue between the front end and the pulse sequencer.
`timescale 1ns / 1ps
module rcpe_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rcpe_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output rcpe_pkg::cmd_type   head_cmd,
   output rcpe_pkg::qstat_type q_stat
);
   import rcpe_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff, count_in;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      if (p == PW'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + PW'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

>>> design/rcpe_back.sv
// Back end: walks one command through its pulse train into the output register.
`timescale 1ns / 1ps
module rcpe_back #(
   parameter int SYMBOLS = rcpe_pkg::RCPE_SYMBOLS
) (
   input  logic                clock,
   input  logic                reset,
   input  rcpe_pkg::qstat_type q_stat,
   input  rcpe_pkg::cmd_type   head_cmd,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic [1:0]          rsp_tuser
);
   import rcpe_pkg::*;

   localparam int SW = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SYNC = 4'b0010,
      ST_LOW  = 4'b0100,
      ST_HIGH = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [SW-1:0]      sym_ff, sym_in;
   logic [SYMBOLS-1:0] shift_ff, shift_in;
   logic [14:0]        t_ff, t_in;
   logic               valid_ff, valid_in;
   logic [15:0]        pulse_ff, pulse_in;
   logic               last_ff, last_in;
   status_type         status_ff, status_in;

   logic               out_free;
   logic [15:0]        t_w;
   logic [15:0]        t2_w;
   logic [SYMBOLS+15:0] code_ext;

   assign out_free = !valid_ff || rsp_tready;
   assign t_w      = {1'b0, t_ff};
   assign t2_w     = {t_ff, 1'b0};
   assign code_ext = {{SYMBOLS{1'b0}}, head_cmd.code};
   assign pop      = out_free && (state_ff == ST_IDLE) && !q_stat.empty;

   always_comb begin
      state_in  = state_ff;
      sym_in    = sym_ff;
      shift_in  = shift_ff;
      t_in      = t_ff;
      valid_in  = valid_ff && !rsp_tready;
      pulse_in  = pulse_ff;
      last_in   = last_ff;
      status_in = status_ff;
      if (out_free) begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  valid_in  = 1'b1;
                  status_in = head_cmd.status;
                  if (head_cmd.status != STATUS_OK) begin
                     pulse_in = 16'd0;
                     last_in  = 1'b1;
                  end else begin
                     // The pilot low is registered as the command is taken and goes out in the cycle after.
                     pulse_in = 16'd0 - {1'b0, head_cmd.pilot};
                     last_in  = 1'b0;
                     t_in     = head_cmd.t;
                     shift_in = code_ext[SYMBOLS-1:0];
                     sym_in   = '0;
                     state_in = ST_SYNC;
                  end
               end
            end
            ST_SYNC: begin
               valid_in = 1'b1;
               pulse_in = t_w;
               last_in  = 1'b0;
               state_in = ST_LOW;
            end
            ST_LOW: begin
               valid_in = 1'b1;
               pulse_in = 16'd0 - (shift_ff[SYMBOLS-1] ? t2_w : t_w);
               last_in  = 1'b0;
               state_in = ST_HIGH;
            end
            ST_HIGH: begin
               valid_in = 1'b1;
               pulse_in = shift_ff[SYMBOLS-1] ? t_w : t2_w;
               shift_in = shift_ff << 1;
               if (sym_ff == SW'(SYMBOLS - 1)) begin
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  last_in  = 1'b0;
                  sym_in   = sym_ff + SW'(1);
                  state_in = ST_LOW;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff    <= sym_in;
      shift_ff  <= shift_in;
      t_ff      <= t_in;
      pulse_ff  <= pulse_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = pulse_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = status_ff;

endmodule

>>> design/remote_code_pulse_encoder_unit.sv
// Top level of the remote code pulse encoder: front end, command queue and sequencer.
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tdata code, symbol_count, capacity; tuser protocol_ok
//  rsp      out        rsp_tvalid/tready    tdata pulse; tlast last; tuser status
//  csr      in         csr_valid/ready      csr_index, csr_wdata
//
// A good request yields 2 + 2*SYMBOLS results (26 by default), one per cycle from the
// sequencer while the response is not stalled; an error request yields a single result.
// Requests are checked on entry and wait in a two-entry queue, so a new request is taken
// while the previous train is still being sent.
// Reset is synchronous and clears the queue, the sequencer state and the output valid flag.
// A stalled response holds the sequencer in place; the queue fills and then stalls req.
`timescale 1ns / 1ps
module remote_code_pulse_encoder_unit #(
   parameter int SYMBOLS = rcpe_pkg::RCPE_SYMBOLS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [15:0] code, [23:16] symbol_count, [39:24] capacity
   input  logic        req_tuser,   // [0] protocol_ok
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] pulse
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import rcpe_pkg::*;

   qstat_type q_stat;
   cmd_type   push_cmd;
   cmd_type   head_cmd;
   logic      push;
   logic      pop;

   rcpe_front #(
      .SYMBOLS(SYMBOLS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .code         (req_tdata[15:0]),
      .protocol_ok  (req_tuser),
      .symbol_count (req_tdata[23:16]),
      .capacity     (req_tdata[39:24]),
      .q_stat       (q_stat),
      .push         (push),
      .cmd          (push_cmd)
   );

   rcpe_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   rcpe_back #(
      .SYMBOLS(SYMBOLS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

`ifndef NO_ASSERTIONS
   // An accepted request is held in the queue at the next edge.
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !q_stat.empty)
      else $error("accepted request did not reach the queue");

   // An error result is always a lone, zero-width, final result.
   a_error_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != STATUS_OK)) |-> (rsp_tlast && (rsp_tdata == 16'd0)))
      else $error("error result is not a single final zero pulse");

   // Pulses of a good train never have zero width.
   a_ok_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == STATUS_OK)) |-> (rsp_tdata != 16'd0))
      else $error("good train carries a zero-width pulse");

   // The sequencer only takes a command when one is present.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("command taken from an empty queue");
`endif

endmodule
